// ----- hdl/u8cyr_pkg.sv -----
package u8cyr_pkg;

    localparam logic [7:0] LEAD_D0     = 8'hD0;
    localparam logic [7:0] LEAD_D1     = 8'hD1;
    localparam logic [7:0] LEAD_E2     = 8'hE2;
    localparam logic [7:0] CONT_84     = 8'h84;
    localparam logic [7:0] CONT_96     = 8'h96;
    localparam logic [7:0] NUMERO_CODE = 8'hCC;
    localparam logic [7:0] D0_IO_BYTE  = 8'h81;
    localparam logic [7:0] D0_IO_CODE  = 8'hA2;
    localparam logic [7:0] D1_YO_BYTE  = 8'h91;
    localparam logic [7:0] D1_YO_CODE  = 8'hB5;
    localparam logic [7:0] D0_TAB_LO   = 8'h90;
    localparam logic [7:0] D0_TAB_HI   = 8'hBF;
    localparam logic [7:0] D1_TAB_LO   = 8'h80;
    localparam logic [7:0] D1_TAB_HI   = 8'h8F;
    localparam logic [7:0] REPL_RESET  = 8'h20;

    localparam int D0_TAB_DEPTH = 48;
    localparam int D1_TAB_DEPTH = 16;

    localparam logic [7:0] D0_TAB [D0_TAB_DEPTH] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE
    };

    localparam logic [7:0] D1_TAB [D1_TAB_DEPTH] = '{
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_TRUNC   = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_D0   = 5'b00010,
        PH_D1   = 5'b00100,
        PH_E2   = 5'b01000,
        PH_E284 = 5'b10000
    } phase_t;

    typedef struct packed {
        logic       d0_hit;
        logic [7:0] d0_code;
        logic       d1_hit;
        logic [7:0] d1_code;
    } lookup_t;

endpackage

// ----- hdl/u8cyr_glyph_rom.sv -----
module u8cyr_glyph_rom (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [7:0]          rd_byte,
    output u8cyr_pkg::lookup_t  rd_data
);

    u8cyr_pkg::lookup_t data_reg;
    logic [5:0]         d0_idx;
    logic [3:0]         d1_idx;
    logic               d0_in_tab;
    logic               d1_in_tab;

    assign d0_idx    = 6'(rd_byte - u8cyr_pkg::D0_TAB_LO);
    assign d1_idx    = rd_byte[3:0];
    assign d0_in_tab = (rd_byte >= u8cyr_pkg::D0_TAB_LO) && (rd_byte <= u8cyr_pkg::D0_TAB_HI);
    assign d1_in_tab = (rd_byte >= u8cyr_pkg::D1_TAB_LO) && (rd_byte <= u8cyr_pkg::D1_TAB_HI);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (rd_byte == u8cyr_pkg::D0_IO_BYTE)
            begin
                data_reg.d0_hit  <= 1'b1;
                data_reg.d0_code <= u8cyr_pkg::D0_IO_CODE;
            end
            else if (d0_in_tab)
            begin
                data_reg.d0_hit  <= 1'b1;
                data_reg.d0_code <= u8cyr_pkg::D0_TAB[d0_idx];
            end
            else
            begin
                data_reg.d0_hit  <= 1'b0;
                data_reg.d0_code <= 8'h00;
            end

            if (rd_byte == u8cyr_pkg::D1_YO_BYTE)
            begin
                data_reg.d1_hit  <= 1'b1;
                data_reg.d1_code <= u8cyr_pkg::D1_YO_CODE;
            end
            else if (d1_in_tab)
            begin
                data_reg.d1_hit  <= 1'b1;
                data_reg.d1_code <= u8cyr_pkg::D1_TAB[d1_idx];
            end
            else
            begin
                data_reg.d1_hit  <= 1'b0;
                data_reg.d1_code <= 8'h00;
            end
        end
    end

    assign rd_data = data_reg;

endmodule

// ----- hdl/utf8_cyrillic_to_lcd_charset_top.sv -----
// Transcodes a UTF-8 byte stream into glyph codes of a Cyrillic character-LCD ROM.
// Input beats (in_byte, in_last) arrive on a valid/ready channel; result beats
// (glyph_code, status, out_last) leave on another. A byte that opens or extends
// a multi-byte sequence gives no result unless it is the last byte of the string,
// in which case one truncated-status result is given.
// The register replacement_code is written through cfg_wr_en and cfg_wr_data and
// resets to 0x20; write it only while the block is idle.
// The block takes one byte per cycle while the output is not stalled: the lookup
// stage reads the glyph ROM, then the byte is resolved against the decode phase and
// its result is loaded into the output register.
// When the receiver holds out_ready low, the output register keeps its beat and
// the lookup stage holds; in_ready falls once both stages are full and rises in
// the same cycle the output is taken.
// Reset (rst_n low) empties both stages, returns the decoder to idle and restores
// the replacement code; no ROM clearing is needed.
module utf8_cyrillic_to_lcd_charset_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] glyph_code,
    output logic [1:0] status,
    output logic       out_last
);

    logic [7:0]          repl_reg;
    logic                s1_valid_reg;
    logic [7:0]          s1_byte_reg;
    logic                s1_last_reg;
    u8cyr_pkg::lookup_t  s1_lookup;
    u8cyr_pkg::phase_t   phase_reg;
    u8cyr_pkg::phase_t   phase_next;
    u8cyr_pkg::phase_t   pend_phase;
    logic                pending;
    logic                res_valid;
    logic [7:0]          res_code;
    u8cyr_pkg::status_t  res_status;
    logic                res_last;
    logic                out_valid_reg;
    logic [7:0]          out_code_reg;
    u8cyr_pkg::status_t  out_status_reg;
    logic                out_last_reg;
    logic                advance;
    logic                in_fire;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    u8cyr_glyph_rom u_rom (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_byte (in_byte),
        .rd_data (s1_lookup)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg <= u8cyr_pkg::REPL_RESET;
        end
        else if (cfg_wr_en)
        begin
            repl_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
    end

    always_comb
    begin
        res_valid  = 1'b0;
        res_code   = s1_byte_reg;
        res_status = u8cyr_pkg::ST_OK;
        res_last   = s1_last_reg;
        pending    = 1'b0;
        pend_phase = u8cyr_pkg::PH_IDLE;
        phase_next = u8cyr_pkg::PH_IDLE;
        unique case (phase_reg)
            u8cyr_pkg::PH_D0:
            begin
                res_valid  = 1'b1;
                res_code   = s1_lookup.d0_hit ? s1_lookup.d0_code : repl_reg;
                res_status = s1_lookup.d0_hit ? u8cyr_pkg::ST_OK : u8cyr_pkg::ST_UNKNOWN;
            end
            u8cyr_pkg::PH_D1:
            begin
                res_valid  = 1'b1;
                res_code   = s1_lookup.d1_hit ? s1_lookup.d1_code : repl_reg;
                res_status = s1_lookup.d1_hit ? u8cyr_pkg::ST_OK : u8cyr_pkg::ST_UNKNOWN;
            end
            u8cyr_pkg::PH_E2:
            begin
                if (s1_byte_reg == u8cyr_pkg::CONT_84)
                begin
                    pending    = 1'b1;
                    pend_phase = u8cyr_pkg::PH_E284;
                end
                else
                begin
                    res_valid  = 1'b1;
                    res_code   = repl_reg;
                    res_status = u8cyr_pkg::ST_UNKNOWN;
                end
            end
            u8cyr_pkg::PH_E284:
            begin
                res_valid = 1'b1;
                if (s1_byte_reg == u8cyr_pkg::CONT_96)
                begin
                    res_code = u8cyr_pkg::NUMERO_CODE;
                end
                else
                begin
                    res_code   = repl_reg;
                    res_status = u8cyr_pkg::ST_UNKNOWN;
                end
            end
            default:
            begin
                priority if (s1_byte_reg == u8cyr_pkg::LEAD_D0)
                begin
                    pending    = 1'b1;
                    pend_phase = u8cyr_pkg::PH_D0;
                end
                else if (s1_byte_reg == u8cyr_pkg::LEAD_D1)
                begin
                    pending    = 1'b1;
                    pend_phase = u8cyr_pkg::PH_D1;
                end
                else if (s1_byte_reg == u8cyr_pkg::LEAD_E2)
                begin
                    pending    = 1'b1;
                    pend_phase = u8cyr_pkg::PH_E2;
                end
                else
                begin
                    res_valid = 1'b1;
                end
            end
        endcase

        if (pending)
        begin
            if (s1_last_reg)
            begin
                res_valid  = 1'b1;
                res_code   = repl_reg;
                res_status = u8cyr_pkg::ST_TRUNC;
                res_last   = 1'b1;
            end
            else
            begin
                phase_next = pend_phase;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= u8cyr_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
            end
            if (advance && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_code_reg   <= res_code;
            out_status_reg <= res_status;
            out_last_reg   <= res_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign glyph_code = out_code_reg;
    assign status     = out_status_reg;
    assign out_last   = out_last_reg;

    // The decoder phase is always exactly one of its one-hot codes.
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("decode phase lost its one-hot form");

    // The last byte of a string always leaves the decoder idle.
    a_last_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_last_reg) |=> (phase_reg == u8cyr_pkg::PH_IDLE))
        else $error("sequence still pending after the last byte");

    // A byte that ends a string always produces a result beat.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_last_reg) |=> (out_valid_reg && out_last_reg))
        else $error("last byte produced no result beat");

    // A truncated-status beat always marks the end of the string.
    a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == u8cyr_pkg::ST_TRUNC)) |-> out_last_reg)
        else $error("truncated status without end marker");

    // A lead byte that opens a sequence mid-string gives no result beat.
    a_pending_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && pending && !s1_last_reg) |-> !res_valid)
        else $error("pending sequence produced a result");

endmodule
